[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg: shared types, constants and helpers of the pitch step command block
// Fixed-point scale factors, mode and register codes and the stage structs.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Encoder resolution; every encoder width below follows from it.
   localparam int ENCODER_BITS = 14;
   localparam int DELTA_W      = ENCODER_BITS + 1;
   localparam int CSR_DATA_W   = (ENCODER_BITS > 16) ? ENCODER_BITS : 16;
   localparam int CSR_INDEX_W  = 2;

   // Angles in degrees, Q.7, wide enough for a difference of two bound angles.
   localparam int ANG_W = 17;
   localparam int MAG_W = 16;
   localparam int STEP_W = 17;

   localparam logic signed [ANG_W-1:0] DEG180_Q7 = 17'sd23040;
   localparam logic signed [ANG_W-1:0] DEG360_Q7 = 17'sd46080;

   // Encoder counts to motor steps and to blade angle, both over 2^ENCODER_BITS.
   localparam int SCALE_W = 17;
   localparam int PROD_W  = ENCODER_BITS + SCALE_W;
   localparam logic [SCALE_W-1:0] ENC_STEP_FACTOR  = 17'd58778;
   localparam logic [SCALE_W-1:0] ENC_ANGLE_FACTOR = 17'd69120;

   // Blade angle to motor steps: 29389 / 34560, where 34560 = 256 * 135.
   localparam int ANG_NUM_W = 15;
   localparam logic [ANG_NUM_W-1:0] ANGLE_STEP_NUM = 15'd29389;
   localparam int ANG_PROD_W  = MAG_W + ANG_NUM_W;
   localparam int DIV_PRE_SHIFT = 8;
   localparam int DIV_X_W     = 22;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 30;
   localparam int QUOT_W      = 15;
   localparam int DIV_PROD_W  = DIV_X_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_135 = 23'd7953644;

   localparam logic [15:0] STEP_LIMIT_RESET = 16'd1000;

   // Mode codes.
   localparam logic [1:0] MODE_ENCODER = 2'd0;
   localparam logic [1:0] MODE_FEATHER = 2'd1;
   localparam logic [1:0] MODE_ANGLE   = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_POSITION    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEATHER_POSITION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LIMIT       = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic       send;
      logic       feather;
   } psc_flags_type;

   // Encoder front end to step conversion.
   typedef struct packed {
      logic                     valid;
      psc_flags_type            flags;
      logic                     neg;
      logic signed [ANG_W-1:0]  target;
      logic [PROD_W-1:0]        prod;
   } psc_scaled_type;

   // Step conversion to output stage.
   typedef struct packed {
      logic             valid;
      psc_flags_type    flags;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } psc_steps_type;

   // Bring an angle once into plus or minus 180 degrees.
   function automatic logic signed [ANG_W-1:0] bound_semi(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] r;
      if (a < -DEG180_Q7) begin
         r = a + DEG360_Q7;
      end else if (a > DEG180_Q7) begin
         r = a - DEG360_Q7;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

[hdl/psc_if.sv]
// ----------------------------------------------------------------------------
// psc_if: request and response channels of the pitch step command block
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface psc_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        mode;
   logic [psc_pkg::ENCODER_BITS-1:0]  encoder_now;
   logic [psc_pkg::ENCODER_BITS-1:0]  encoder_goal;
   logic signed [15:0]                angle_goal;
   logic                              drive_done;
   logic                              feather_reported;

   modport source (output valid, mode, encoder_now, encoder_goal, angle_goal,
                   drive_done, feather_reported, input ready);
   modport sink   (input valid, mode, encoder_now, encoder_goal, angle_goal,
                   drive_done, feather_reported, output ready);
endinterface

interface psc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [psc_pkg::STEP_W-1:0] step_count;
   logic                              send_steps;
   logic                              send_feather_enable;

   modport source (output valid, step_count, send_steps, send_feather_enable,
                   input ready);
   modport sink   (input valid, step_count, send_steps, send_feather_enable,
                   output ready);
endinterface

[hdl/psc_encoder.sv]
// ----------------------------------------------------------------------------
// psc_encoder: encoder difference and scaling stages
// Wraps the encoder difference, takes its magnitude and scales it.
// ----------------------------------------------------------------------------
module psc_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [1:0]                        mode,
   input  logic [psc_pkg::ENCODER_BITS-1:0]  encoder_now,
   input  logic [psc_pkg::ENCODER_BITS-1:0]  encoder_goal,
   input  logic signed [15:0]                angle_goal,
   input  logic                              drive_done,
   input  logic                              feather_reported,
   input  logic [psc_pkg::ENCODER_BITS-1:0]  zero_position,
   input  logic [psc_pkg::ENCODER_BITS-1:0]  feather_position,
   output psc_pkg::psc_scaled_type           scaled
);

   localparam int E = psc_pkg::ENCODER_BITS;
   localparam int DW = psc_pkg::DELTA_W;
   localparam int AW = psc_pkg::ANG_W;

   // Stage 1: wrapped difference and bound target angle.
   logic                       v1_ff;
   psc_pkg::psc_flags_type     flags1_ff, flags1_in;
   logic signed [DW-1:0]       d1_ff, d1_in;
   logic signed [AW-1:0]       target1_ff, target1_in;

   // Stage 2: magnitude and direction.
   logic                       v2_ff;
   psc_pkg::psc_flags_type     flags2_ff;
   logic [E-1:0]               mag2_ff, mag2_in;
   logic                       neg2_ff, neg2_in;
   logic signed [AW-1:0]       target2_ff;

   // Stage 3: scaled magnitude.
   logic                       v3_ff;
   psc_pkg::psc_flags_type     flags3_ff;
   logic                       neg3_ff;
   logic signed [AW-1:0]       target3_ff;
   logic [psc_pkg::PROD_W-1:0] prod3_ff, prod3_in;

   logic [E-1:0]               ref_pos;
   logic [DW-1:0]              diff;
   logic [DW-1:0]              abs_d;
   logic [psc_pkg::SCALE_W-1:0] factor;

   always_comb begin
      case (mode)
         psc_pkg::MODE_FEATHER: ref_pos = feather_position;
         psc_pkg::MODE_ANGLE:   ref_pos = zero_position;
         default:               ref_pos = encoder_goal;
      endcase
      diff = {1'b0, encoder_now} - {1'b0, ref_pos};
      // Two's-complement wrap, except that half a turn maps to plus half when encoder_now is below the reference.
      if (diff[E-1] && (diff[E-2:0] == '0) && diff[E]) begin
         d1_in = {1'b0, diff[E-1:0]};
      end else begin
         d1_in = {diff[E-1], diff[E-1:0]};
      end
      target1_in = psc_pkg::bound_semi(AW'(angle_goal));
      flags1_in.mode    = mode;
      flags1_in.send    = drive_done && (mode != psc_pkg::MODE_NONE);
      flags1_in.feather = (mode == psc_pkg::MODE_FEATHER) && drive_done && !feather_reported;
   end

   always_comb begin
      abs_d   = d1_ff[DW-1] ? -d1_ff : d1_ff;
      mag2_in = abs_d[E-1:0];
      if (flags1_ff.mode == psc_pkg::MODE_ANGLE) begin
         neg2_in = d1_ff < 0;
      end else begin
         neg2_in = d1_ff > 0;
      end
   end

   always_comb begin
      factor   = (flags2_ff.mode == psc_pkg::MODE_ANGLE) ? psc_pkg::ENC_ANGLE_FACTOR
                                                          : psc_pkg::ENC_STEP_FACTOR;
      prod3_in = {{psc_pkg::SCALE_W{1'b0}}, mag2_ff} * {{E{1'b0}}, factor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff      <= in_valid;
         flags1_ff  <= flags1_in;
         d1_ff      <= d1_in;
         target1_ff <= target1_in;

         v2_ff      <= v1_ff;
         flags2_ff  <= flags1_ff;
         mag2_ff    <= mag2_in;
         neg2_ff    <= neg2_in;
         target2_ff <= target1_ff;

         v3_ff      <= v2_ff;
         flags3_ff  <= flags2_ff;
         neg3_ff    <= neg2_ff;
         target3_ff <= target2_ff;
         prod3_ff   <= prod3_in;
      end
   end

   assign scaled.valid  = v3_ff;
   assign scaled.flags  = flags3_ff;
   assign scaled.neg    = neg3_ff;
   assign scaled.target = target3_ff;
   assign scaled.prod   = prod3_ff;

endmodule

[hdl/psc_steps.sv]
// ----------------------------------------------------------------------------
// psc_steps: blade angle and step conversion stages
// Forms the angle error in mode 2 and converts it to motor steps; other modes pass the step magnitude through.
// ----------------------------------------------------------------------------
module psc_steps (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  psc_pkg::psc_scaled_type scaled,
   output psc_pkg::psc_steps_type  steps
);

   localparam int E  = psc_pkg::ENCODER_BITS;
   localparam int AW = psc_pkg::ANG_W;
   localparam int MW = psc_pkg::MAG_W;

   // Stage 4: current angle (mode 2) or step magnitude (other modes).
   logic                        v4_ff;
   psc_pkg::psc_flags_type      flags4_ff;
   logic                        neg4_ff;
   logic signed [AW-1:0]        target4_ff;
   logic signed [AW-1:0]        val4_ff, val4_in;

   // Stage 5: raw angle error.
   logic                        v5_ff;
   psc_pkg::psc_flags_type      flags5_ff;
   logic                        neg5_ff;
   logic signed [AW-1:0]        val5_ff, val5_in;

   // Stage 6: bound error magnitude and sign.
   logic                        v6_ff;
   psc_pkg::psc_flags_type      flags6_ff;
   logic                        neg6_ff, neg6_in;
   logic [MW-1:0]               mag6_ff, mag6_in;

   // Stage 7: numerator product.
   logic                        v7_ff;
   psc_pkg::psc_flags_type      flags7_ff;
   logic                        neg7_ff;
   logic [MW-1:0]               mag7_ff;
   logic [psc_pkg::ANG_PROD_W-1:0] p7_ff, p7_in;

   // Stage 8: division by 34560 through a shift and a reciprocal of 135.
   logic                        v8_ff;
   psc_pkg::psc_flags_type      flags8_ff;
   logic                        neg8_ff;
   logic [MW-1:0]               mag8_ff, mag8_in;

   logic [MW-1:0]               m4;
   logic signed [AW-1:0]        cur4;
   logic signed [AW-1:0]        err6;
   logic signed [AW-1:0]        abs6;
   logic [psc_pkg::DIV_X_W-1:0]    x8;
   logic [psc_pkg::DIV_PROD_W-1:0] q8_prod;

   always_comb begin
      m4   = scaled.prod[E +: MW];
      cur4 = scaled.neg ? -AW'(m4) : AW'(m4);
      if (scaled.flags.mode == psc_pkg::MODE_ANGLE) begin
         val4_in = psc_pkg::bound_semi(cur4);
      end else begin
         val4_in = AW'(m4);
      end
   end

   always_comb begin
      if (flags4_ff.mode == psc_pkg::MODE_ANGLE) begin
         val5_in = target4_ff - val4_ff;
      end else begin
         val5_in = val4_ff;
      end
   end

   always_comb begin
      err6 = psc_pkg::bound_semi(val5_ff);
      abs6 = (err6 < 0) ? -err6 : err6;
      if (flags5_ff.mode == psc_pkg::MODE_ANGLE) begin
         mag6_in = abs6[MW-1:0];
         neg6_in = err6 < 0;
      end else begin
         mag6_in = val5_ff[MW-1:0];
         neg6_in = neg5_ff;
      end
   end

   always_comb begin
      p7_in = {{psc_pkg::ANG_NUM_W{1'b0}}, mag6_ff} *
              {{MW{1'b0}}, psc_pkg::ANGLE_STEP_NUM};
   end

   always_comb begin
      x8      = p7_ff[psc_pkg::DIV_PRE_SHIFT +: psc_pkg::DIV_X_W];
      q8_prod = {{psc_pkg::RECIP_W{1'b0}}, x8} *
                {{psc_pkg::DIV_X_W{1'b0}}, psc_pkg::RECIP_135};
      if (flags7_ff.mode == psc_pkg::MODE_ANGLE) begin
         mag8_in = MW'(q8_prod[psc_pkg::RECIP_SHIFT +: psc_pkg::QUOT_W]);
      end else begin
         mag8_in = mag7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v4_ff      <= scaled.valid;
         flags4_ff  <= scaled.flags;
         neg4_ff    <= scaled.neg;
         target4_ff <= scaled.target;
         val4_ff    <= val4_in;

         v5_ff      <= v4_ff;
         flags5_ff  <= flags4_ff;
         neg5_ff    <= neg4_ff;
         val5_ff    <= val5_in;

         v6_ff      <= v5_ff;
         flags6_ff  <= flags5_ff;
         neg6_ff    <= neg6_in;
         mag6_ff    <= mag6_in;

         v7_ff      <= v6_ff;
         flags7_ff  <= flags6_ff;
         neg7_ff    <= neg6_ff;
         mag7_ff    <= mag6_ff;
         p7_ff      <= p7_in;

         v8_ff      <= v7_ff;
         flags8_ff  <= flags7_ff;
         neg8_ff    <= neg7_ff;
         mag8_ff    <= mag8_in;
      end
   end

   assign steps.valid = v8_ff;
   assign steps.flags = flags8_ff;
   assign steps.neg   = neg8_ff;
   assign steps.mag   = mag8_ff;

endmodule

[hdl/pitch_step_command.sv]
// ----------------------------------------------------------------------------
// pitch_step_command: blade pitch stepper command generator
// Each request transaction carries a mode, the encoder reading, the goals and
// two drive flags; each yields one response transaction with a signed step
// count, clamped to the step limit, and the two command flags.
// Configuration registers (zero position, feather position, step limit) are
// written through the csr_ port, one register per cycle with csr_we high;
// the user must write them only while no transaction is in flight (not enforced).
// The datapath is a nine-stage pipeline: wrap, magnitude, encoder scaling,
// angle bound, angle error, error bound, numerator product, reciprocal
// division and saturation. Throughput is one transaction per cycle, as every
// stage takes a new transaction on each cycle in which the response side is
// not stalled.
// When the receiver holds rsp ready low with a response waiting, the whole
// pipeline freezes and req ready falls in the same cycle; nothing is lost or
// repeated and the response is held stable.
// Synchronous reset empties the pipeline, clears zero and feather positions
// and sets the step limit to 1000.
// ----------------------------------------------------------------------------
module pitch_step_command (
   input  logic                               clock,
   input  logic                               reset,
   psc_req_if.sink                            req_chan,
   psc_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [psc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int E  = psc_pkg::ENCODER_BITS;
   localparam int MW = psc_pkg::MAG_W;
   localparam int SW = psc_pkg::STEP_W;

   logic [E-1:0]  zero_position_ff;
   logic [E-1:0]  feather_position_ff;
   logic [15:0]   step_limit_ff;

   // The pipeline moves whenever the output register is free or being drained.
   logic en;

   psc_pkg::psc_scaled_type scaled;
   psc_pkg::psc_steps_type  steps;

   logic                 rsp_valid_ff;
   logic signed [SW-1:0] step_count_ff, step_count_in;
   logic                 send_steps_ff;
   logic                 send_feather_ff;
   logic [MW-1:0]        mag_sat;

   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_position_ff    <= '0;
         feather_position_ff <= '0;
         step_limit_ff       <= psc_pkg::STEP_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            psc_pkg::CSR_ZERO_POSITION:    zero_position_ff    <= csr_wdata[E-1:0];
            psc_pkg::CSR_FEATHER_POSITION: feather_position_ff <= csr_wdata[E-1:0];
            psc_pkg::CSR_STEP_LIMIT:       step_limit_ff       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   psc_encoder u_encoder (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_chan.valid),
      .mode             (req_chan.mode),
      .encoder_now      (req_chan.encoder_now),
      .encoder_goal     (req_chan.encoder_goal),
      .angle_goal       (req_chan.angle_goal),
      .drive_done       (req_chan.drive_done),
      .feather_reported (req_chan.feather_reported),
      .zero_position    (zero_position_ff),
      .feather_position (feather_position_ff),
      .scaled           (scaled)
   );

   psc_steps u_steps (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .scaled (scaled),
      .steps  (steps)
   );

   // Final stage: clamp the magnitude to the step limit and apply the sign.
   // The unused mode code reports no steps at all.
   always_comb begin
      if (steps.flags.mode == psc_pkg::MODE_NONE) begin
         mag_sat = '0;
      end else if (steps.mag > step_limit_ff) begin
         mag_sat = step_limit_ff;
      end else begin
         mag_sat = steps.mag;
      end
      step_count_in = steps.neg ? -SW'(mag_sat) : SW'(mag_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff    <= steps.valid;
         step_count_ff   <= step_count_in;
         send_steps_ff   <= steps.flags.send;
         send_feather_ff <= steps.flags.feather;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.step_count          = step_count_ff;
   assign rsp_chan.send_steps          = send_steps_ff;
   assign rsp_chan.send_feather_enable = send_feather_ff;

endmodule
